@@ hdl/msfi_pkg.sv @@
// Shared types and constants of the MPEG start-code frame indexer.
package msfi_pkg;

  localparam int DEFAULT_FRAME_BITS    = 32;
  localparam int DEFAULT_POSITION_BITS = 48;
  localparam int QUEUE_DEPTH           = 4;

  localparam int BYTE_POS_BITS  = 48;
  localparam int S_TDATA_BITS   = 56;
  localparam int M_TDATA_BITS   = 160;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIST_BITS      = 11;
  localparam int DIVISOR_BITS   = 10;

  localparam logic [23:0] SCAN_RESET   = 24'hFFFFFF;
  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [23:0] PES_FIRST    = 24'h0001E0;
  localparam logic [23:0] PES_LAST     = 24'h0001EF;
  localparam logic [23:0] GOP_CODE     = 24'h0001B8;
  localparam logic [23:0] PICTURE_CODE = 24'h000100;

  localparam logic [2:0] PIC_TYPE_I = 3'd1;
  localparam logic [2:0] PIC_TYPE_P = 3'd2;
  localparam logic [2:0] PIC_TYPE_B = 3'd3;

  localparam logic [31:0]                  STOP_FRAME_RESET = 32'hFFFFFFFF;
  localparam logic signed [DIST_BITS-1:0]  DIST_UNKNOWN     = -11'sd1;
  localparam logic signed [DIST_BITS-1:0]  DIST_ONE         = 11'sd1;
  localparam logic signed [DIST_BITS-1:0]  DIST_MAX         = 11'sd1023;
  localparam logic signed [DIST_BITS-1:0]  DIST_MIN         = -11'sd1024;
  localparam logic signed [DIST_BITS-1:0]  DIST_GOP_12      = 11'sd12;
  localparam logic signed [DIST_BITS-1:0]  DIST_GOP_15      = 11'sd15;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STOP_FRAME     = 3'd0,
    REG_START_FRAME    = 3'd1,
    REG_PRESET_DIST    = 3'd2,
    REG_DISTANCE_KNOWN = 3'd3,
    REG_FULL_MAP       = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_QUEUED = 2'd0,
    EV_STOP   = 2'd1,
    EV_GOP    = 2'd2
  } event_kind_t;

  typedef enum logic {
    CMD_PICTURE = 1'b0,
    CMD_GOP     = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic                      en;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic                        mark_by_gop;
    logic signed [DIST_BITS-1:0] keyframe_distance;
    logic                        distance_new;
    logic [31:0]                 map_index;
    logic                        map_entry_valid;
    logic [47:0]                 stream_offset;
    logic [31:0]                 decoder_frame_count;
    logic [31:0]                 frame_number;
  } result_t;

  localparam int M_PAD_BITS = M_TDATA_BITS - $bits(result_t);

endpackage

@@ hdl/mpeg_start_code_frame_indexer.sv @@
// Top level of the MPEG start-code frame indexer.
//
// Bytes of a program stream enter on the s_ group, one beat per byte, with the
// absolute stream offset alongside. A scanner finds 00 00 01 start codes at one
// byte per cycle and queues picture and GOP commands into a four-entry queue;
// the event unit drains the queue and drives one result beat per command on m_.
// A picture result is written into the output register as the unit pops its
// command. A GOP that may add a map entry divides the key frame number by the
// keyframe distance one quotient bit per cycle. Sustained rate is one byte per
// cycle while the queue has room; s_tready drops only when the queue is full.
// A stalled m_ side holds its beat; the unit keeps one result in its output
// register, and the scanner keeps taking bytes until the queue fills.
// Synchronous reset restores the frame and queue counters and register defaults.
// Configuration writes on cfg_ are always ready and are meant for idle times.
module mpeg_start_code_frame_indexer #(
  parameter int FRAME_BITS    = msfi_pkg::DEFAULT_FRAME_BITS,
  parameter int POSITION_BITS = msfi_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [msfi_pkg::S_TDATA_BITS-1:0]   s_tdata,   // data_byte, byte_position
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [msfi_pkg::M_TDATA_BITS-1:0]   m_tdata,   // frame_number, decoder_frame_count,
                                                         // stream_offset, map_entry_valid,
                                                         // map_index, distance_new,
                                                         // keyframe_distance, mark_by_gop
  output logic [1:0]                          m_tuser,   // event_kind
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msfi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [msfi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import msfi_pkg::*;

  localparam int ENTRY_BITS = POSITION_BITS + 1;

  logic                     accept;
  logic                     push;
  cmd_kind_t                push_kind;
  logic [POSITION_BITS-1:0] push_offset;
  logic [ENTRY_BITS-1:0]    pop_data;
  logic                     pop;
  logic                     fifo_full;
  logic                     fifo_empty;
  cfg_write_t               cfg;
  event_kind_t              out_kind;
  result_t                  out_result;

  assign cfg_ready = 1'b1;
  assign cfg       = {cfg_valid && cfg_ready, cfg_index, cfg_data};
  assign s_tready  = !fifo_full;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {M_PAD_BITS'(0), out_result};
  assign m_tuser   = out_kind;

  msfi_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata[7:0]),
    .byte_position(s_tdata[S_TDATA_BITS-1:8]),
    .push         (push),
    .push_kind    (push_kind),
    .push_offset  (push_offset)
  );

  msfi_fifo #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_offset, push_kind}),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  msfi_back #(
    .FRAME_BITS   (FRAME_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry_valid (!fifo_empty),
    .entry_kind  (cmd_kind_t'(pop_data[0])),
    .entry_offset(pop_data[ENTRY_BITS-1:1]),
    .pop         (pop),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_kind    (out_kind),
    .out_result  (out_result)
  );

  assert property (@(posedge clk) disable iff (rst) push |-> !fifo_full)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> !fifo_empty)
    else $error("command popped from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_result.map_entry_valid || out_result.distance_new) |-> out_kind == EV_GOP)
    else $error("map or distance flag on a picture result");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind == EV_QUEUED |-> out_result.stream_offset == '0)
    else $error("queued frame result carries an offset");

endmodule

@@ hdl/msfi_front.sv @@
// Front scanner: finds start codes and queues picture and GOP commands.
module msfi_front #(
  parameter int POSITION_BITS = msfi_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [7:0]                         data_byte,
  input  logic [msfi_pkg::BYTE_POS_BITS-1:0] byte_position,
  output logic                               push,
  output msfi_pkg::cmd_kind_t                push_kind,
  output logic [POSITION_BITS-1:0]           push_offset
);
  import msfi_pkg::*;

  logic [23:0]              scan_shift;
  logic [23:0]              scan_shift_next;
  logic [1:0]               countdown;
  logic [POSITION_BITS-1:0] picture_pos;
  logic [POSITION_BITS-1:0] packet_pos;
  logic [POSITION_BITS-1:0] code_start;
  logic [2:0]               pic_type;
  logic                     after_prefix;
  logic                     pic_fire;
  logic                     is_pes;
  logic                     is_gop;
  logic                     is_pic;

  always_comb begin
    code_start      = POSITION_BITS'(byte_position) - POSITION_BITS'(3);
    scan_shift_next = {scan_shift[15:0], data_byte};
    after_prefix    = (scan_shift == START_PREFIX);
    pic_type        = data_byte[5:3];
    pic_fire        = (countdown == 2'd1) &&
                      (pic_type == PIC_TYPE_I || pic_type == PIC_TYPE_P ||
                       pic_type == PIC_TYPE_B);
    is_pes          = after_prefix && (scan_shift_next >= PES_FIRST) &&
                      (scan_shift_next <= PES_LAST);
    is_gop          = after_prefix && (scan_shift_next == GOP_CODE);
    is_pic          = after_prefix && (scan_shift_next == PICTURE_CODE);
    push            = accept && (pic_fire || is_gop);
    push_kind       = pic_fire ? CMD_PICTURE : CMD_GOP;
    push_offset     = pic_fire ? picture_pos : packet_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_shift  <= SCAN_RESET;
      countdown   <= 2'd0;
      picture_pos <= '0;
      packet_pos  <= '0;
    end else if (accept) begin
      scan_shift <= scan_shift_next;
      if (is_pic) begin
        countdown   <= 2'd2;
        picture_pos <= code_start;
      end else if (countdown != 2'd0) begin
        countdown <= countdown - 2'd1;
      end
      if (is_pes) begin
        packet_pos <= code_start;
      end
    end
  end

endmodule

@@ hdl/msfi_fifo.sv @@
// Short command queue between the scanner and the event unit.
module msfi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = msfi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import msfi_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

@@ hdl/msfi_back.sv @@
// Event unit: frame counters, keyframe distance, map division and result register.
module msfi_back #(
  parameter int FRAME_BITS    = msfi_pkg::DEFAULT_FRAME_BITS,
  parameter int POSITION_BITS = msfi_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  msfi_pkg::cfg_write_t     cfg,
  input  logic                     entry_valid,
  input  msfi_pkg::cmd_kind_t      entry_kind,
  input  logic [POSITION_BITS-1:0] entry_offset,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output msfi_pkg::event_kind_t    out_kind,
  output msfi_pkg::result_t        out_result
);
  import msfi_pkg::*;

  localparam int CNT_BITS = $clog2(FRAME_BITS + 1);
  localparam int CMP_BITS = (FRAME_BITS > 32) ? FRAME_BITS : 32;

  back_state_t state;
  back_state_t state_next;

  logic [31:0]                 stop_frame;
  logic                        full_map;
  logic [FRAME_BITS-1:0]       frames_read;
  logic [FRAME_BITS-1:0]       queued_count;
  logic [FRAME_BITS-1:0]       first_gop_frame;
  logic [FRAME_BITS-1:0]       last_entry_index;
  logic signed [DIST_BITS-1:0] learned_distance;
  logic                        distance_settled;

  logic [FRAME_BITS-1:0]       gop_fn;
  logic [POSITION_BITS-1:0]    gop_offset;
  logic                        gop_dnew;
  logic                        map_try;
  logic [DIVISOR_BITS-1:0]     divisor;
  logic [FRAME_BITS-1:0]       quo;
  logic [DIVISOR_BITS-1:0]     rem;
  logic [CNT_BITS-1:0]         div_count;

  logic                        out_free;
  logic                        emit_pic;
  logic                        load_gop;
  logic                        emit_gop;
  logic                        below_stop;
  logic [FRAME_BITS-1:0]       frames_inc;
  logic [FRAME_BITS-1:0]       queued_inc;
  logic                        dist_update;
  logic                        dist_learn;
  logic signed [FRAME_BITS:0]  diff;
  logic signed [DIST_BITS-1:0] clamped;
  logic signed [DIST_BITS-1:0] new_dist;
  logic                        map_try_next;
  logic [DIVISOR_BITS:0]       shifted;
  logic                        div_ge;
  logic [DIVISOR_BITS-1:0]     rem_step;
  logic                        gop_valid;
  logic                        mark;
  event_kind_t                 kind_next;
  result_t                     result_next;

  always_comb begin
    out_free   = !out_valid || out_ready;
    below_stop = CMP_BITS'(frames_read) < CMP_BITS'(stop_frame);
    frames_inc = frames_read + FRAME_BITS'(1);
    queued_inc = queued_count + FRAME_BITS'(1);

    dist_update = !distance_settled && (frames_read != '0);
    dist_learn  = dist_update && (first_gop_frame != '0) && (learned_distance != DIST_ONE);
    diff        = $signed({1'b0, frames_read}) - $signed({1'b0, first_gop_frame});
    if (!diff[FRAME_BITS] && (|diff[FRAME_BITS-1:DIST_BITS-1])) begin
      clamped = DIST_MAX;
    end else if (diff[FRAME_BITS] && !(&diff[FRAME_BITS-1:DIST_BITS-1])) begin
      clamped = DIST_MIN;
    end else begin
      clamped = diff[DIST_BITS-1:0];
    end
    new_dist     = dist_learn ? clamped : learned_distance;
    map_try_next = !full_map && !new_dist[DIST_BITS-1] && (new_dist != '0);

    shifted  = {rem, quo[FRAME_BITS-1]};
    div_ge   = shifted >= {1'b0, divisor};
    rem_step = div_ge ? DIVISOR_BITS'(shifted - {1'b0, divisor}) : shifted[DIVISOR_BITS-1:0];

    gop_valid = map_try && ((quo > last_entry_index) ||
                            ((quo == last_entry_index) && (rem != '0)));
    mark      = (learned_distance == DIST_GOP_12) || (learned_distance == DIST_GOP_15);
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (entry_valid && out_free && entry_kind == CMD_GOP) begin
          state_next = map_try_next ? BK_DIVIDE : BK_EMIT;
        end
      end
      BK_DIVIDE: begin
        if (div_count == CNT_BITS'(1)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = (state == BK_IDLE) && entry_valid && out_free;
    emit_pic    = pop && (entry_kind == CMD_PICTURE);
    load_gop    = pop && (entry_kind == CMD_GOP);
    emit_gop    = (state == BK_EMIT) && out_free;
    result_next = '0;
    result_next.keyframe_distance = learned_distance;
    result_next.mark_by_gop       = mark;
    if (emit_gop) begin
      kind_next                       = EV_GOP;
      result_next.frame_number        = 32'(gop_fn);
      result_next.decoder_frame_count = 32'(queued_count);
      result_next.stream_offset       = 48'(gop_offset);
      result_next.map_entry_valid     = gop_valid;
      result_next.map_index           = gop_valid ? 32'(quo) : '0;
      result_next.distance_new        = gop_dnew;
    end else if (below_stop) begin
      kind_next                       = EV_QUEUED;
      result_next.frame_number        = 32'(frames_inc);
      result_next.decoder_frame_count = 32'(queued_inc);
    end else begin
      kind_next                       = EV_STOP;
      result_next.frame_number        = 32'(frames_inc);
      result_next.decoder_frame_count = 32'(queued_count);
      result_next.stream_offset       = 48'(entry_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= BK_IDLE;
      stop_frame       <= STOP_FRAME_RESET;
      full_map         <= 1'b0;
      frames_read      <= '0;
      queued_count     <= '0;
      first_gop_frame  <= '0;
      last_entry_index <= '0;
      learned_distance <= DIST_UNKNOWN;
      distance_settled <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.en) begin
        case (cfg.index)
          REG_STOP_FRAME:     stop_frame       <= cfg.data;
          REG_START_FRAME:    frames_read      <= FRAME_BITS'(cfg.data);
          REG_PRESET_DIST:    learned_distance <= cfg.data[DIST_BITS-1:0];
          REG_DISTANCE_KNOWN: distance_settled <= cfg.data[0];
          REG_FULL_MAP:       full_map         <= cfg.data[0];
          default: ;
        endcase
      end
      if (emit_pic) begin
        frames_read <= frames_inc;
        if (below_stop) begin
          queued_count <= queued_inc;
        end
      end
      if (load_gop && dist_update) begin
        if (dist_learn) begin
          learned_distance <= clamped;
          distance_settled <= 1'b1;
        end else begin
          first_gop_frame <= frames_read;
        end
      end
      if (emit_gop && gop_valid) begin
        last_entry_index <= quo;
      end
      if (emit_pic || emit_gop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_gop) begin
      gop_fn     <= frames_read;
      gop_offset <= entry_offset;
      gop_dnew   <= dist_learn;
      map_try    <= map_try_next;
      divisor    <= new_dist[DIVISOR_BITS-1:0];
      quo        <= frames_read;
      rem        <= '0;
      div_count  <= CNT_BITS'(FRAME_BITS);
    end else if (state == BK_DIVIDE) begin
      quo       <= {quo[FRAME_BITS-2:0], div_ge};
      rem       <= rem_step;
      div_count <= div_count - CNT_BITS'(1);
    end
    if (emit_pic || emit_gop) begin
      out_kind   <= kind_next;
      out_result <= result_next;
    end
  end

endmodule

@@ sim/tb_mpeg_start_code_frame_indexer.sv @@
// Self-checking testbench for the MPEG start-code frame indexer.
module tb_mpeg_start_code_frame_indexer;
  timeunit 1ns;
  timeprecision 1ps;

  import msfi_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int SCRIPT_ROWS = 24;
  localparam int DRAIN_CYCLES = 50;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int PHASES = 9;

  typedef struct {
    event_kind_t kind;
    result_t     res;
  } indexed_event_t;

  typedef struct {
    logic [7:0]  data;
    logic [47:0] pos;
    bit          typed;
    event_kind_t kind;
    logic [31:0] fn;
    logic [47:0] off;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  mpeg_start_code_frame_indexer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_mpeg_start_code_frame_indexer NOT OK");
    $finish;
  end

  // indexer state as seen from outside
  logic [23:0]             scan_window = SCAN_RESET;
  logic [31:0]             frame_ctr = 32'd0;
  logic [31:0]             queued_ctr = 32'd0;
  logic [31:0]             first_gop_fn = 32'd0;
  logic [31:0]             last_map_index = 32'd0;
  logic [47:0]             pes_start = 48'd0;
  logic [47:0]             pic_start = 48'd0;
  logic                    settled = 1'b0;
  logic signed [DIST_BITS-1:0] kf_dist = DIST_UNKNOWN;
  logic [1:0]              type_wait = 2'd0;
  logic [31:0]             stop_at = STOP_FRAME_RESET;
  logic                    map_full = 1'b0;

  indexed_event_t pending_events[$];
  int             mismatches = 0;
  logic [47:0]    stream_pos = 48'd0;
  int             bytes_sent = 0;
  bit             calm = 1'b0;
  bit             want_long_hold = 1'b0;

  script_row_t script [SCRIPT_ROWS] = '{
    '{8'h00, 48'd0, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd1, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h01, 48'd2, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'hB8, 48'd3, 1'b1, EV_GOP, 32'd0, 48'd0},
    '{8'h00, 48'd4, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd5, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h01, 48'd6, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'hE0, 48'd7, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd8, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd9, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h01, 48'd10, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd11, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'hFF, 48'd12, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h08, 48'd13, 1'b1, EV_QUEUED, 32'd1, 48'd0},
    '{8'h00, 48'hFFFF_FFFF_FFFE, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'hFFFF_FFFF_FFFF, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h01, 48'd0, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd1, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd2, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h38, 48'd3, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd4, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h00, 48'd5, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'h01, 48'd6, 1'b0, EV_QUEUED, 32'd0, 48'd0},
    '{8'hB8, 48'd7, 1'b1, EV_GOP, 32'd1, 48'd4}
  };

  function automatic void fill_common(ref indexed_event_t ev);
    ev.res.decoder_frame_count = queued_ctr;
    ev.res.keyframe_distance   = kf_dist;
    ev.res.mark_by_gop         = (kf_dist == DIST_GOP_12 || kf_dist == DIST_GOP_15);
  endfunction

  function automatic bit finish_picture(input logic [7:0] b, ref indexed_event_t ev);
    logic [2:0] ptype;
    ptype = b[5:3];
    if (ptype != PIC_TYPE_I && ptype != PIC_TYPE_P && ptype != PIC_TYPE_B) return 1'b0;
    ev.res = '0;
    if (frame_ctr < stop_at) begin
      queued_ctr = queued_ctr + 32'd1;
      frame_ctr  = frame_ctr + 32'd1;
      ev.kind = EV_QUEUED;
    end else begin
      frame_ctr = frame_ctr + 32'd1;
      ev.kind = EV_STOP;
      ev.res.stream_offset = pic_start;
    end
    ev.res.frame_number = frame_ctr;
    fill_common(ev);
    return 1'b1;
  endfunction

  function automatic void open_gop(ref indexed_event_t ev);
    logic [31:0] fn, diff, d, q, r;
    fn = frame_ctr;
    ev.kind = EV_GOP;
    ev.res = '0;
    if (!settled && fn != 32'd0) begin
      if (first_gop_fn != 32'd0 && kf_dist != DIST_ONE) begin
        if (fn >= first_gop_fn) begin
          diff = fn - first_gop_fn;
          kf_dist = (diff > 32'd1023) ? DIST_MAX : diff[DIST_BITS-1:0];
        end else begin
          diff = first_gop_fn - fn;
          d = 32'd0 - diff;
          kf_dist = (diff > 32'd1024) ? DIST_MIN : d[DIST_BITS-1:0];
        end
        settled = 1'b1;
        ev.res.distance_new = 1'b1;
      end else begin
        first_gop_fn = fn;
      end
    end
    if (!map_full && kf_dist > 0) begin
      d = {21'd0, kf_dist};
      q = fn / d;
      r = fn % d;
      if (q > last_map_index || (q == last_map_index && r != 32'd0)) begin
        ev.res.map_entry_valid = 1'b1;
        ev.res.map_index = q;
        last_map_index = q;
      end
    end
    ev.res.frame_number  = fn;
    ev.res.stream_offset = pes_start;
    fill_common(ev);
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input logic [47:0] pos,
                                   ref indexed_event_t ev);
    logic [47:0] code_start;
    bit          after_prefix;
    bit          got;
    code_start   = pos - 48'd3;
    after_prefix = (scan_window == START_PREFIX);
    got = 1'b0;
    if (type_wait != 2'd0) begin
      type_wait = type_wait - 2'd1;
      if (type_wait == 2'd0) got = finish_picture(b, ev);
    end
    scan_window = {scan_window[15:0], b};
    if (after_prefix) begin
      if (scan_window >= PES_FIRST && scan_window <= PES_LAST) begin
        pes_start = code_start;
      end else if (scan_window == GOP_CODE) begin
        if (!got) begin
          open_gop(ev);
          got = 1'b1;
        end
      end else if (scan_window == PICTURE_CODE) begin
        type_wait = 2'd2;
        pic_start = code_start;
      end
    end
    return got;
  endfunction

  function automatic logic [31:0] pad_noise(input logic [31:0] v, input int keep);
    logic [31:0] mask;
    mask = (32'd1 << keep) - 32'd1;
    return (v & mask) | ($urandom & ~mask);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 50)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_beat(input logic [1:0] kind, input result_t seen);
    indexed_event_t want;
    if (pending_events.size() == 0) begin
      note_mismatch("unexpected beat, event_kind", 64'(kind), 64'd0);
      return;
    end
    want = pending_events[0];
    pending_events.delete(0);
    if (kind !== want.kind)
      note_mismatch("event_kind", 64'(kind), 64'(want.kind));
    if (seen.frame_number !== want.res.frame_number)
      note_mismatch("frame_number", 64'(seen.frame_number), 64'(want.res.frame_number));
    if (seen.decoder_frame_count !== want.res.decoder_frame_count)
      note_mismatch("decoder_frame_count", 64'(seen.decoder_frame_count),
                    64'(want.res.decoder_frame_count));
    if (seen.stream_offset !== want.res.stream_offset)
      note_mismatch("stream_offset", 64'(seen.stream_offset), 64'(want.res.stream_offset));
    if (seen.map_entry_valid !== want.res.map_entry_valid)
      note_mismatch("map_entry_valid", 64'(seen.map_entry_valid),
                    64'(want.res.map_entry_valid));
    if (seen.map_index !== want.res.map_index)
      note_mismatch("map_index", 64'(seen.map_index), 64'(want.res.map_index));
    if (seen.distance_new !== want.res.distance_new)
      note_mismatch("distance_new", 64'(seen.distance_new), 64'(want.res.distance_new));
    if (seen.keyframe_distance !== want.res.keyframe_distance)
      note_mismatch("keyframe_distance", 64'($unsigned(seen.keyframe_distance)),
                    64'($unsigned(want.res.keyframe_distance)));
    if (seen.mark_by_gop !== want.res.mark_by_gop)
      note_mismatch("mark_by_gop", 64'(seen.mark_by_gop), 64'(want.res.mark_by_gop));
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input event_kind_t kind = EV_QUEUED,
                           input logic [31:0] fn = 32'd0, input logic [47:0] off = 48'd0);
    indexed_event_t ev;
    bit got;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stream_pos, b};
    do @(posedge clk); while (!s_tready);
    ev.kind = EV_QUEUED;
    ev.res = '0;
    got = scan_byte(b, stream_pos, ev);
    if (typed) begin
      ev.kind = kind;
      ev.res.frame_number = fn;
      ev.res.stream_offset = off;
      got = 1'b1;
    end
    if (got) pending_events = {pending_events, ev};
    stream_pos = stream_pos + 48'd1;
    bytes_sent++;
  endtask

  task automatic send_prefix();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
  endtask

  task automatic send_segment(input bit dense);
    int pick;
    logic [2:0] ptype;
    pick = dense ? $urandom_range(0, 54) : $urandom_range(0, 99);
    if (!dense && $urandom_range(0, 19) == 0)
      stream_pos = $urandom_range(0, 1) ? 48'({$urandom, $urandom})
                                        : 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 8));
    if (pick < 40) begin
      send_prefix();
      send_byte(PICTURE_CODE[7:0]);
      send_byte(8'($urandom));
      ptype = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(1, 3));
      send_byte({2'($urandom), ptype, 3'($urandom)});
      repeat (dense ? 0 : $urandom_range(0, 3)) send_byte(8'($urandom));
    end else if (pick < 55) begin
      send_prefix();
      send_byte(GOP_CODE[7:0]);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
    end else if (pick < 67) begin
      send_prefix();
      send_byte({4'hE, 4'($urandom)});
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
    end else if (pick < 75) begin
      send_prefix();
      send_byte(8'($urandom_range(1, 175)));
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
    end else if (pick < 82) begin
      send_prefix();
      send_byte(8'($urandom));
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      send_byte(8'h00);
      send_byte($urandom_range(0, 1) ? 8'h00 : 8'h01);
      send_byte(8'($urandom_range(2, 255)));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STOP_FRAME:     stop_at = val;
      REG_START_FRAME:    frame_ctr = val;
      REG_PRESET_DIST:    kf_dist = val[DIST_BITS-1:0];
      REG_DISTANCE_KNOWN: settled = val[0];
      REG_FULL_MAP:       map_full = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : sink
    int hold_left;
    int idle_left;
    hold_left = 0;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_beat(m_tuser, m_tdata[$bits(result_t)-1:0]);
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : source
    int budget;
    int first_byte;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      stream_pos = script[i].pos;
      send_byte(script[i].data, script[i].typed, script[i].kind, script[i].fn, script[i].off);
    end
    s_tvalid <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      calm = (ph == PHASES - 1);
      case (ph)
        0: begin
          write_reg(REG_STOP_FRAME, STOP_FRAME_RESET);
          write_reg(REG_START_FRAME, 32'd0);
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_UNKNOWN}, DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd0, 1));
          write_reg(REG_FULL_MAP, pad_noise(32'd0, 1));
        end
        1: begin
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_GOP_12}, DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd1, 1));
          write_reg(REG_START_FRAME, 32'd0);
        end
        2: begin
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_GOP_15}, DIST_BITS));
          write_reg(REG_START_FRAME, 32'hFFFF_FFF8);
          write_reg(REG_STOP_FRAME, STOP_FRAME_RESET);
        end
        3: begin
          write_reg(REG_STOP_FRAME, 32'd0);
          write_reg(REG_FULL_MAP, pad_noise(32'd1, 1));
          write_reg(REG_UNMAPPED, $urandom);
        end
        4: begin
          write_reg(REG_STOP_FRAME, 32'($urandom_range(1, 20)));
          write_reg(REG_START_FRAME, 32'd0);
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd0, 1));
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_ONE}, DIST_BITS));
          write_reg(REG_FULL_MAP, pad_noise(32'd0, 1));
        end
        5: begin
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_MIN}, DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd1, 1));
          write_reg(REG_START_FRAME, 32'hFFFF_FFFF);
          write_reg(REG_STOP_FRAME, STOP_FRAME_RESET);
        end
        6: begin
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_MAX}, DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd0, 1));
          write_reg(REG_START_FRAME, 32'h8000_0000);
        end
        7: begin
          write_reg(REG_PRESET_DIST, pad_noise({21'd0, DIST_ONE}, DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd0, 1));
          write_reg(REG_START_FRAME, 32'hC000_0000);
        end
        default: begin
          write_reg(REG_PRESET_DIST, pad_noise(32'($urandom_range(2, 1023)), DIST_BITS));
          write_reg(REG_DISTANCE_KNOWN, pad_noise(32'd0, 1));
          write_reg(REG_START_FRAME, 32'($urandom_range(1, 100)));
          write_reg(REG_STOP_FRAME, 32'($urandom_range(50, 300)));
          write_reg(REG_FULL_MAP, pad_noise(32'($urandom_range(0, 1)), 1));
        end
      endcase
      cfg_valid <= 1'b0;
      if (ph == 1) want_long_hold = 1'b1;
      budget = (ph == 1) ? 90 : 45;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < budget) send_segment(ph == 1);
      s_tvalid <= 1'b0;
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_mpeg_start_code_frame_indexer OK");
    end else begin
      $display("tb_mpeg_start_code_frame_indexer NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/msfi_pkg.sv
hdl/msfi_front.sv
hdl/msfi_fifo.sv
hdl/msfi_back.sv
hdl/mpeg_start_code_frame_indexer.sv
sim/tb_mpeg_start_code_frame_indexer.sv
